// ===== hw/rtl/uvt_pkg.sv =====
`timescale 1ns / 1ps

package uvt_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_CONTAINS = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic                       success;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
        logic                       table_full;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the new item, restart the scan
        logic add;      // append key at the end
        logic clear;    // drop all entries
        logic scan;     // issue the next read, compare the previous one
        logic rd_last;  // read the last filled entry
        logic move;     // write the last entry into the matched slot
        logic finish;   // register the result
        logic ok;       // success flag for the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic is_full;
        logic hit;
        logic miss;
    } t_dp_stat;

endpackage

// ===== hw/rtl/uvt_ram.sv =====
`timescale 1ns / 1ps

module uvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/uvt_datapath.sv =====
`timescale 1ns / 1ps

module uvt_datapath #(
    parameter int CAPACITY = uvt_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uvt_pkg::t_in_item  i_item,
    input  uvt_pkg::t_dp_cmd   i_cmd,
    output uvt_pkg::t_dp_stat  o_stat,
    output uvt_pkg::t_out_item o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    uvt_pkg::t_op                 r_op;
    logic [uvt_pkg::VALUE_W-1:0]  r_key;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic                         r_pend, n_pend;
    logic [AW-1:0]                r_slot;
    uvt_pkg::t_out_item           r_res;

    logic [CNT_W-1:0]             idx_prev;
    logic [CNT_W-1:0]             count_last;
    logic                         idx_at_end;
    logic                         match;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [uvt_pkg::VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [uvt_pkg::VALUE_W-1:0]  ram_rdata;

    assign idx_prev   = r_idx - CNT_W'(1);
    assign count_last = r_count - CNT_W'(1);
    assign idx_at_end = (r_idx == r_count);
    assign match      = r_pend && (ram_rdata == r_key);

    // read data always belongs to the address issued in the previous cycle
    assign ram_raddr = i_cmd.rd_last ? count_last[AW-1:0] : r_idx[AW-1:0];
    assign ram_we    = i_cmd.add | i_cmd.move;
    assign ram_waddr = i_cmd.add ? r_count[AW-1:0] : r_slot;
    assign ram_wdata = i_cmd.add ? r_key : ram_rdata;

    uvt_ram #(
        .WIDTH (uvt_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.add) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.move) begin
            n_count = count_last;
        end

        n_idx  = r_idx;
        n_pend = r_pend;
        if (i_cmd.load) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end else if (i_cmd.scan) begin
            n_pend = !idx_at_end;
            if (!idx_at_end) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_key <= i_item.value;
        end
        if (i_cmd.scan && match) begin
            r_slot <= idx_prev[AW-1:0];
        end
        if (i_cmd.finish) begin
            r_res.success     <= i_cmd.ok;
            r_res.entry_count <= uvt_pkg::ENTRY_COUNT_W'(n_count);
            r_res.table_full  <= (n_count == CNT_W'(CAPACITY));
        end
    end

    assign o_stat.op      = r_op;
    assign o_stat.is_full = (r_count == CNT_W'(CAPACITY));
    assign o_stat.hit     = match;
    assign o_stat.miss    = idx_at_end && !match;
    assign o_result       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |-> (r_count != CNT_W'(CAPACITY)))
        else $error("append into a full table");

    a_move_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> (r_count != '0))
        else $error("remove from an empty table");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_res.table_full == (r_count == CNT_W'(CAPACITY))))
        else $error("table_full disagrees with entry count");

endmodule

// ===== hw/rtl/uvt_ctrl.sv =====
`timescale 1ns / 1ps

module uvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  uvt_pkg::t_dp_stat i_stat,
    output uvt_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RD_LAST,
        S_MOVE
    } t_state;

    t_state           r_state, n_state;
    logic             r_done;
    uvt_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    uvt_pkg::OP_ADD: begin
                        cmd.add    = !i_stat.is_full;
                        cmd.ok     = !i_stat.is_full;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                    uvt_pkg::OP_CONTAINS, uvt_pkg::OP_REMOVE: begin
                        n_state = S_SCAN;
                    end
                    uvt_pkg::OP_CLEAR: begin
                        cmd.clear  = 1'b1;
                        cmd.ok     = 1'b1;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    if (i_stat.op == uvt_pkg::OP_REMOVE) begin
                        n_state = S_RD_LAST;
                    end else begin
                        cmd.ok     = 1'b1;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.miss) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RD_LAST: begin
                cmd.rd_last = 1'b1;
                n_state     = S_MOVE;
            end
            S_MOVE: begin
                cmd.move   = 1'b1;
                cmd.ok     = 1'b1;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= cmd.finish;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== hw/rtl/unsorted_value_table_unit.sv =====
`timescale 1ns / 1ps

// Unordered table of signed 32-bit values with a fill count.
// Command channel: drive i_item (op, value) and raise start; the item is
// taken at a clock edge where start is high and busy is low. Ops: add
// appends at the end (rejected when full), contains searches the filled
// entries, remove swaps the last entry into the first match and shrinks
// the count, clear drops every entry.
// Result channel: o_done pulses for one cycle with o_result (success,
// entry_count after the op, table_full). The receiver cannot stall; the
// result must be sampled in that cycle. busy is low again while o_done is
// high, so a new item may be taken in the same cycle.
// Add and clear finish at dispatch; contains and remove scan the filled
// entries from index 0 until a match or the end, and remove then reads
// the last entry and moves it into the matched slot. The scan makes one
// table read a cycle through the single read port of the entry RAM, and
// a new item is taken only after the previous one is done.
// Reset empties the table at once (count cleared); stored words are not
// wiped since only filled entries are ever compared or moved.
module unsorted_value_table_unit #(
    parameter int CAPACITY = uvt_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  uvt_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_done,
    output uvt_pkg::t_out_item o_result
);

    // command and status between sequencer and datapath
    uvt_pkg::t_dp_cmd  dp_cmd;
    uvt_pkg::t_dp_stat dp_stat;

    // sequence each item: dispatch, scan, fetch last, move
    uvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // hold the count, the entry RAM, the scan pointer and the result
    uvt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule
